// ===== src/mcts_pkg.sv =====
// Shared types and constants of the multi-channel timeout scheduler.
package mcts_pkg;

   localparam int KIND_W = 2;
   localparam int CH_W   = 6;
   localparam int TICK_W = 64;

   // Request kinds. A time read and the unused code change nothing.
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

   typedef struct packed {
      logic accept;       // a request is taken at this edge
      logic scan_read;    // read one table entry and advance the scan address
      logic scan_finish;  // fold the last entry and arm the earliest deadline
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_scan;    // the request being taken needs a table rescan
      logic addr_last;    // the scan address points at the last entry
   } dp_status_type;

endpackage

// ===== src/multi_channel_timeout_scheduler.sv =====
// Top level of the multi-channel timeout scheduler.
//
// The scheduler keeps a 64-bit tick count and one one-shot deadline per channel, and
// answers every request with exactly one response carrying the count after the request,
// plus the channel that fired if any. A tick request increments the count and fires the
// armed channel when its deadline is at or before the new count; a set request stores
// count plus delay (wrapping) for its channel and arms it when no channel is armed or it
// is strictly earlier than the armed deadline; a time read and the unused kind only
// report the count. Set requests for channels at or above CHANNELS are ignored. Normally
// the next request can be taken right away as long as the output register is empty or its
// response leaves at the same edge; while a response is stalled, requests are held off. A
// tick that fires, or a set that does not bring the armed channel's own deadline earlier,
// starts a rescan of the deadline memory through its single read port, one entry per
// cycle, and such a request holds off the next one until the rescan is done. The rescan
// arms the earliest valid deadline, the lowest channel on a tie, and at most one channel
// fires per tick, so several channels that are due fire on successive ticks. The deadline
// memory needs no clearing after reset; per-channel valid flags track which entries hold
// a live deadline.
module multi_channel_timeout_scheduler #(
   parameter int CHANNELS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mcts_pkg::KIND_W-1:0]   req_kind,
   input  logic [mcts_pkg::CH_W-1:0]     req_channel,
   input  logic [mcts_pkg::TICK_W-1:0]   req_delay,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mcts_pkg::TICK_W-1:0]   rsp_now_ticks,
   output logic                          rsp_fired,
   output logic [mcts_pkg::CH_W-1:0]     rsp_fired_channel
);
   import mcts_pkg::*;

   // Commands from the controller and status from the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller owns the handshake and the rescan sequencing.
   mcts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the count, the deadline table and the response payload.
   mcts_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_channel       (req_channel),
      .req_delay         (req_delay),
      .rsp_now_ticks     (rsp_now_ticks),
      .rsp_fired         (rsp_fired),
      .rsp_fired_channel (rsp_fired_channel)
   );

endmodule

// ===== src/mcts_ctrl.sv =====
// Controller state machine of the multi-channel timeout scheduler.
module mcts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mcts_pkg::dp_status_type status,
   output mcts_pkg::ctrl_cmd_type  cmd
);
   import mcts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_take;

   // The output register frees up at the same edge at which the next request is taken.
   assign can_take  = (state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !can_take;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept      = can_take && req_valid;
      cmd.scan_read   = (state_ff == ST_SCAN);
      cmd.scan_finish = (state_ff == ST_DRAIN);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.need_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/mcts_dp.sv =====
// Datapath of the multi-channel timeout scheduler: tick count, deadline table and rescan.
module mcts_dp #(
   parameter int CHANNELS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcts_pkg::ctrl_cmd_type         cmd,
   output mcts_pkg::dp_status_type        status,
   input  logic [mcts_pkg::KIND_W-1:0]   req_kind,
   input  logic [mcts_pkg::CH_W-1:0]     req_channel,
   input  logic [mcts_pkg::TICK_W-1:0]   req_delay,
   output logic [mcts_pkg::TICK_W-1:0]   rsp_now_ticks,
   output logic                          rsp_fired,
   output logic [mcts_pkg::CH_W-1:0]     rsp_fired_channel
);
   import mcts_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Architectural state.
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              armed_ff, armed_in;
   logic [TICK_W-1:0] armed_dl_ff, armed_dl_in;
   logic [CH_W-1:0]   armed_ch_ff, armed_ch_in;
   logic              valid_ff [CHANNELS];
   logic [TICK_W-1:0] mem_ff [CHANNELS];

   // Scan pipeline.
   logic [IDX_W-1:0]  scan_addr_ff;
   logic              rd_vld_ff;
   logic              rd_ent_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [TICK_W-1:0] rd_data_ff;
   logic              found_ff, found_in;
   logic [TICK_W-1:0] best_ff, best_in;
   logic [CH_W-1:0]   best_ch_ff, best_ch_in;
   logic              take;

   // Result register.
   logic [TICK_W-1:0] rsp_now_ff;
   logic              rsp_fired_ff;
   logic [CH_W-1:0]   rsp_fch_ff;

   // Request decode.
   logic              is_tick, is_set, in_range, fire, set_wins;
   logic [TICK_W-1:0] tick_next, set_dl;
   logic [IDX_W-1:0]  set_idx, armed_idx;

   assign in_range  = (32'(req_channel) < CHANNELS);
   assign is_tick   = (req_kind == KIND_TICK);
   assign is_set    = (req_kind == KIND_SET) && in_range;
   assign tick_next = tick_ff + 1'b1;
   assign set_dl    = tick_ff + req_delay;
   assign set_idx   = IDX_W'(req_channel);
   assign armed_idx = IDX_W'(armed_ch_ff);
   assign fire      = is_tick && armed_ff && (armed_dl_ff <= tick_next);
   assign set_wins  = !armed_ff || (set_dl < armed_dl_ff);

   always_comb begin
      status.need_scan = fire || (is_set && !set_wins && (armed_ch_ff == req_channel));
      status.addr_last = (scan_addr_ff == IDX_W'(CHANNELS - 1));
   end

   // Running minimum over the entries coming out of the table; ties keep the lower channel.
   assign take = rd_vld_ff && rd_ent_vld_ff && (!found_ff || (rd_data_ff < best_ff));

   always_comb begin
      found_in   = found_ff;
      best_in    = best_ff;
      best_ch_in = best_ch_ff;
      if (cmd.accept) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in   = 1'b1;
         best_in    = rd_data_ff;
         best_ch_in = CH_W'(rd_idx_ff);
      end
   end

   always_comb begin
      tick_in     = tick_ff;
      armed_in    = armed_ff;
      armed_dl_in = armed_dl_ff;
      armed_ch_in = armed_ch_ff;
      if (cmd.accept) begin
         if (is_tick) begin
            tick_in = tick_next;
         end
         if (fire) begin
            armed_in = 1'b0;
         end else if (is_set && set_wins) begin
            armed_in    = 1'b1;
            armed_dl_in = set_dl;
            armed_ch_in = req_channel;
         end
      end else if (cmd.scan_finish) begin
         armed_in    = found_in;
         armed_dl_in = found_in ? best_in : '0;
         armed_ch_in = found_in ? best_ch_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         armed_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         tick_ff   <= tick_in;
         armed_ff  <= armed_in;
         rd_vld_ff <= cmd.scan_read;
         found_ff  <= found_in;
         if (cmd.accept && fire) begin
            valid_ff[armed_idx] <= 1'b0;
         end else if (cmd.accept && is_set) begin
            valid_ff[set_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      armed_dl_ff <= armed_dl_in;
      armed_ch_ff <= armed_ch_in;
      best_ff     <= best_in;
      best_ch_ff  <= best_ch_in;
      if (cmd.accept) begin
         scan_addr_ff <= '0;
         rsp_now_ff   <= is_tick ? tick_next : tick_ff;
         rsp_fired_ff <= fire;
         rsp_fch_ff   <= fire ? armed_ch_ff : '0;
      end else if (cmd.scan_read) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      if (cmd.scan_read) begin
         rd_idx_ff     <= scan_addr_ff;
         rd_ent_vld_ff <= valid_ff[scan_addr_ff];
      end
   end

   // Deadline memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.accept && is_set) begin
         mem_ff[set_idx] <= set_dl;
      end
      if (cmd.scan_read) begin
         rd_data_ff <= mem_ff[scan_addr_ff];
      end
   end

   assign rsp_now_ticks     = rsp_now_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_channel = rsp_fch_ff;

endmodule

// ===== src/mcts_checker.sv =====
// Port-level checker of the multi-channel timeout scheduler and its bind statement.
module mcts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [mcts_pkg::KIND_W-1:0]   req_kind,
   input logic [mcts_pkg::CH_W-1:0]     req_channel,
   input logic [mcts_pkg::TICK_W-1:0]   req_delay,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mcts_pkg::TICK_W-1:0]   rsp_now_ticks,
   input logic                          rsp_fired,
   input logic [mcts_pkg::CH_W-1:0]     rsp_fired_channel
);
   import mcts_pkg::*;

   logic req_take;
   logic last_tick_ff;

   assign req_take = req_valid && !req_stall;

   // Remembers whether the most recently taken request was a tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= 1'b0;
      end else if (req_take) begin
         last_tick_ff <= (req_kind == KIND_TICK);
      end
   end

   // Every taken request produces a response on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("no response after a taken request");

   // Only a tick can fire a channel.
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fired) |-> last_tick_ff)
      else $error("fire reported for a request that was not a tick");

   // Without a fire the channel field reads zero.
   a_idle_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> (rsp_fired_channel == '0))
      else $error("fired channel nonzero without a fire");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_now_ticks)))
      else $error("stalled response changed");

   // Requests are refused while a response is stalled and another would overwrite it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while the response register was blocked");

endmodule

bind multi_channel_timeout_scheduler mcts_checker u_mcts_checker (.*);
